// File: design/point_morton_key_and_weight_macros.svh
`ifndef POINT_MORTON_KEY_AND_WEIGHT_MACROS_SVH
`define POINT_MORTON_KEY_AND_WEIGHT_MACROS_SVH

// Same-cycle implication, checked on aclk, off while aresetn is low.
`define PMK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, off while aresetn is low.
`define PMK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pmk_pkg.sv
package pmk_pkg;

    // Grid and index sizes
    localparam int MAX_DEPTH  = 10;
    localparam int INDEX_BITS = 20;
    localparam int DEPTH_W    = 4;
    localparam int KEY_W      = 3 * MAX_DEPTH;
    localparam int WEIGHT_W   = 16;
    localparam int COORD_W    = 32;

    // Stream payload widths, padded to whole bytes
    localparam int S_DATA_W = ((INDEX_BITS + 3 * COORD_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((KEY_W + INDEX_BITS + WEIGHT_W + 7) / 8) * 8;

    // Register indexes
    localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z   = 3'd2;
    localparam logic [2:0] REG_GRID_SCALE = 3'd3;
    localparam logic [2:0] REG_GRID_DEPTH = 3'd4;

    // Reset values
    localparam logic [31:0]        SCALE_RESET = 32'd65536;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(6);

    // Weight class of one axis, picked from the spline distance
    typedef enum logic [1:0] {
        W_NEAR = 2'd0,   // distance below one half: 0.75 - a^2
        W_MID  = 2'd1,   // half to three halves: 0.5 * (1.5 - a)^2
        W_ONE  = 2'd2,   // distance exactly one half
        W_ZERO = 2'd3    // beyond three halves
    } pmk_wclass_t;

    // Per-axis result handed to the top level
    typedef struct packed {
        logic [MAX_DEPTH-1:0] vox;
        logic                 sat;
        logic [WEIGHT_W-1:0]  weight;
    } pmk_axis_res_t;

    // Interleave three voxel coordinates: bit 3i+2 x, 3i+1 y, 3i z
    function automatic logic [KEY_W-1:0] pmk_interleave(
        input logic [MAX_DEPTH-1:0] vx,
        input logic [MAX_DEPTH-1:0] vy,
        input logic [MAX_DEPTH-1:0] vz
    );
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            k[3*i+2] = vx[i];
            k[3*i+1] = vy[i];
            k[3*i]   = vz[i];
        end
        return k;
    endfunction

endpackage

// File: design/point_morton_key_and_weight.sv
// Point voxelization: takes one beat per cycle while s_tready is high (point
// index and Q16.16 x, y, z) and returns one beat per point with the
// 3-bit-per-level Morton key, the index and the product of the three quadratic
// B-spline weights (Q0.16). Points outside the grid pin to the nearest edge
// voxel and raise tuser. Throughput is one point per clock while m_tready does
// not stall the output; there are eight register stages. The stages are the
// per-axis chain (subtract, 33x32 scale multiply, voxel and distance, classify,
// square, weight) and two stages for the three-way weight product. A one-entry
// skid at the input keeps s_tready a register output. Configuration registers
// may be written only while no point is in flight.
`include "point_morton_key_and_weight_macros.svh"

module point_morton_key_and_weight
    import pmk_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    // point input
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // point_index, coord_x, coord_y, coord_z
    // key output
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // morton_key, index_out, spline_weight
    output logic                m_tuser    // out_of_range
);

    localparam int LAT = 8;

    // Configuration registers
    logic signed [COORD_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [31:0]               scale_reg;
    logic [DEPTH_W-1:0]        depth_reg;
    logic [DEPTH_W-1:0]        depth_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            scale_reg    <= SCALE_RESET;
            depth_reg    <= DEPTH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ORIGIN_X:   origin_x_reg <= cfg_data;
                REG_ORIGIN_Y:   origin_y_reg <= cfg_data;
                REG_ORIGIN_Z:   origin_z_reg <= cfg_data;
                REG_GRID_SCALE: scale_reg    <= cfg_data;
                REG_GRID_DEPTH: depth_reg    <= cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Depth zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (depth_reg == '0) begin
            depth_eff = DEPTH_W'(1);
        end else if (depth_reg > DEPTH_W'(MAX_DEPTH)) begin
            depth_eff = DEPTH_W'(MAX_DEPTH);
        end else begin
            depth_eff = depth_reg;
        end
    end

    // Pipeline advances whenever the output register is free or being taken
    logic pipe_en;
    logic m_tvalid_reg;

    assign pipe_en = !m_tvalid_reg || m_tready;

    // Input skid: holds one beat caught while the pipeline was stalled
    logic                skid_v_reg;
    logic [S_DATA_W-1:0] skid_data_reg;
    logic                in_valid;
    logic [S_DATA_W-1:0] in_data;
    logic                s_accept;

    assign s_tready = !skid_v_reg;
    assign s_accept = s_tvalid && s_tready;
    assign in_valid = skid_v_reg ? 1'b1 : s_tvalid;
    assign in_data  = skid_v_reg ? skid_data_reg : s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_v_reg <= 1'b0;
        end else if (pipe_en) begin
            skid_v_reg <= 1'b0;
        end else if (s_accept) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!pipe_en && s_accept) begin
            skid_data_reg <= s_tdata;
        end
    end

    // Per-axis units
    pmk_axis_res_t res_x, res_y, res_z;

    pmk_axis u_axis_x (
        .aclk   (aclk),
        .en     (pipe_en),
        .coord  (in_data[INDEX_BITS +: COORD_W]),
        .origin (origin_x_reg),
        .scale  (scale_reg),
        .depth  (depth_eff),
        .res    (res_x)
    );

    pmk_axis u_axis_y (
        .aclk   (aclk),
        .en     (pipe_en),
        .coord  (in_data[INDEX_BITS+COORD_W +: COORD_W]),
        .origin (origin_y_reg),
        .scale  (scale_reg),
        .depth  (depth_eff),
        .res    (res_y)
    );

    pmk_axis u_axis_z (
        .aclk   (aclk),
        .en     (pipe_en),
        .coord  (in_data[INDEX_BITS+2*COORD_W +: COORD_W]),
        .origin (origin_z_reg),
        .scale  (scale_reg),
        .depth  (depth_eff),
        .res    (res_z)
    );

    // Valid bits and point index ride alongside the axis stages
    logic [LAT-2:0]        valid_reg;
    logic [INDEX_BITS-1:0] idx_reg [LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en) begin
            valid_reg    <= {valid_reg[LAT-3:0], in_valid};
            m_tvalid_reg <= valid_reg[LAT-2];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            idx_reg[0] <= in_data[INDEX_BITS-1:0];
            for (int i = 1; i < LAT - 1; i++) begin
                idx_reg[i] <= idx_reg[i-1];
            end
        end
    end

    // Stage 7: key, flag, first weight product
    logic [31:0]           wxy_reg;
    logic [WEIGHT_W-1:0]   wz_reg;
    logic [KEY_W-1:0]      key_reg;
    logic                  flag_reg;

    // Stage 8: output register, top half of the triple product
    logic [47:0]           wxyz;
    logic [KEY_W-1:0]      key_out_reg;
    logic [INDEX_BITS-1:0] idx_out_reg;
    logic [WEIGHT_W-1:0]   weight_out_reg;
    logic                  flag_out_reg;

    assign wxyz = wxy_reg * wz_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            wxy_reg        <= res_x.weight * res_y.weight;
            wz_reg         <= res_z.weight;
            key_reg        <= pmk_interleave(res_x.vox, res_y.vox, res_z.vox);
            flag_reg       <= res_x.sat | res_y.sat | res_z.sat;
            key_out_reg    <= key_reg;
            idx_out_reg    <= idx_reg[LAT-2];
            weight_out_reg <= wxyz[47:32];
            flag_out_reg   <= flag_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = flag_out_reg;
    assign m_tdata  = {(M_DATA_W - KEY_W - INDEX_BITS - WEIGHT_W)'(0),
                       weight_out_reg, idx_out_reg, key_out_reg};

    // A beat caught during a stall must land in the skid
    `PMK_ASSERT_NEXT(a_skid_fill, s_accept && !pipe_en, skid_v_reg, "beat lost on stall")
    // Last internal stage moves into the output register when enabled
    `PMK_ASSERT_NEXT(a_out_load, pipe_en && valid_reg[LAT-2], m_tvalid_reg, "beat dropped")
    // Every in-grid axis weighs at least one half, so the product is at least 1/8
    `PMK_ASSERT_SAME(a_min_weight, m_tvalid_reg && !flag_out_reg,
                     weight_out_reg >= WEIGHT_W'(8192), "in-grid weight too small")

endmodule

// File: design/pmk_axis.sv
// One axis: offset, scale, voxel coordinate, spline distance, weight.
// Six register stages, all advancing on en.
module pmk_axis
    import pmk_pkg::*;
(
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [COORD_W-1:0] coord,
    input  logic signed [COORD_W-1:0] origin,
    input  logic [31:0]               scale,
    input  logic [DEPTH_W-1:0]        depth,
    output pmk_axis_res_t             res
);

    localparam logic [63:0] HALF_Q32  = 64'h0000_0000_8000_0000;
    localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
    localparam logic [32:0] HALF_A    = 33'h0_8000_0000;
    localparam logic [32:0] THREE_H_A = 33'h1_8000_0000;
    localparam logic [32:0] ONE_A     = 33'h1_0000_0000;
    localparam logic [63:0] NEAR_TOP  = 64'hC000_0000_0000_0000;

    // Stage 1: offset from the box origin, sign and magnitude
    logic signed [32:0] diff;
    logic [32:0]        mag_next, mag_reg;
    logic               neg1_reg;

    assign diff     = {coord[31], coord} - {origin[31], origin};
    assign mag_next = diff[32] ? (~diff + 33'd1) : diff;

    // Stage 2: scaled position, Q32.32
    logic [64:0] prod;
    logic [63:0] t_reg;
    logic        neg2_reg;

    assign prod = mag_reg * scale;

    // Stage 3: voxel coordinate, saturation, spline distance
    logic [MAX_DEPTH:0]   limit;
    logic [31:0]          ip, hi, frac;
    logic                 beyond;
    logic [32:0]          a_next, a_reg;
    logic                 far_next, far_reg;
    logic [MAX_DEPTH-1:0] vox_next, vox3_reg;
    logic                 sat_next, sat3_reg;

    assign limit  = (MAX_DEPTH+1)'(1) << depth;
    assign ip     = t_reg[63:32];
    assign frac   = t_reg[31:0];
    assign beyond = ip >= 32'(limit);
    assign hi     = ip - 32'(limit);

    always_comb begin
        if (neg2_reg && (t_reg != 64'd0)) begin
            // below the box: pinned to voxel zero
            vox_next = '0;
            sat_next = 1'b1;
            far_next = t_reg > ONE_Q32;
            a_next   = t_reg[32:0] + HALF_A;
        end else if (beyond) begin
            // past the far edge: pinned to the last voxel
            vox_next = MAX_DEPTH'(limit - (MAX_DEPTH+1)'(1));
            sat_next = 1'b1;
            far_next = (hi > 32'd1) || ((hi == 32'd1) && (frac != 32'd0));
            a_next   = {hi[0], frac} + HALF_A;
        end else begin
            vox_next = ip[MAX_DEPTH-1:0];
            sat_next = 1'b0;
            far_next = 1'b0;
            a_next   = ({1'b0, frac} > HALF_Q32[32:0]) ? ({1'b0, frac} - HALF_A)
                                                      : (HALF_A - {1'b0, frac});
        end
    end

    // Stage 4: weight class and the operand to square
    logic [32:0]          b;
    pmk_wclass_t          cls_next, cls4_reg, cls5_reg;
    logic [31:0]          op_next, op_reg;
    logic [MAX_DEPTH-1:0] vox4_reg, vox5_reg;
    logic                 sat4_reg, sat5_reg;

    assign b = THREE_H_A - a_reg;

    always_comb begin
        if (far_reg || (a_reg > THREE_H_A)) begin
            cls_next = W_ZERO;
            op_next  = '0;
        end else if (a_reg < HALF_A) begin
            cls_next = W_NEAR;
            op_next  = a_reg[31:0];
        end else if (b == ONE_A) begin
            cls_next = W_ONE;
            op_next  = '0;
        end else begin
            cls_next = W_MID;
            op_next  = b[31:0];
        end
    end

    // Stage 5: square
    logic [63:0] sq_next, sq_reg;

    assign sq_next = op_reg * op_reg;

    // Stage 6: weight in Q0.16
    logic [WEIGHT_W-1:0] w_next;

    always_comb begin
        case (cls5_reg)
            W_NEAR:  w_next = WEIGHT_W'((NEAR_TOP - sq_reg) >> 48);
            W_MID:   w_next = WEIGHT_W'(sq_reg >> 49);
            W_ONE:   w_next = WEIGHT_W'(32768);
            default: w_next = '0;
        endcase
    end

    pmk_axis_res_t res_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg        <= mag_next;
            neg1_reg       <= diff[32];
            t_reg          <= prod[63:0];
            neg2_reg       <= neg1_reg;
            a_reg          <= a_next;
            far_reg        <= far_next;
            vox3_reg       <= vox_next;
            sat3_reg       <= sat_next;
            op_reg         <= op_next;
            cls4_reg       <= cls_next;
            vox4_reg       <= vox3_reg;
            sat4_reg       <= sat3_reg;
            sq_reg         <= sq_next;
            cls5_reg       <= cls4_reg;
            vox5_reg       <= vox4_reg;
            sat5_reg       <= sat4_reg;
            res_reg.vox    <= vox5_reg;
            res_reg.sat    <= sat5_reg;
            res_reg.weight <= w_next;
        end
    end

    assign res = res_reg;

endmodule
